@@ design/grouped_radix_digit_formatter_defines.svh @@
// Assertion macros shared by the formatter modules.
// Depends on nothing; users provide signals named clock and reset.
`ifndef GROUPED_RADIX_DIGIT_FORMATTER_DEFINES_SVH
`define GROUPED_RADIX_DIGIT_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
`define GRDF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("grdf property violated");
`define GRDF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("grdf sequence violated");
`else
`define GRDF_ASSERT(label, prop)
`define GRDF_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ design/grdf_pkg.sv @@
// Shared constants, types and character helpers for the radix formatter.
// Used by every module of the block; depends on nothing.
package grdf_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int IN_WIDTH    = 32;
   localparam int IDX_W       = $clog2(VALUE_WIDTH);
   localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int FUNC_W      = 2;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 7;

   localparam logic [FUNC_W-1:0] FUNC_HEX = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_OCT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_BIN = 2'd3;

   localparam logic [CHAR_W-1:0] CHR_COMMA      = 7'h2C;
   localparam logic [CHAR_W-1:0] CHR_SPACE      = 7'h20;
   localparam logic [CHAR_W-1:0] CHR_ZERO       = 7'h30;
   localparam logic [CHAR_W-1:0] CHR_ALPHA_BASE = 7'h37;

   typedef logic [VALUE_WIDTH-1:0][DIGIT_W-1:0] digit_row_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] count;
      logic [1:0]       cmod;
   } conv_status_type;

   // Group size minus one: 3 for hex and binary, 2 for decimal and octal.
   function automatic logic [1:0] group_max(input logic [FUNC_W-1:0] func);
      logic [1:0] g;
      case (func)
         FUNC_HEX: g = 2'd3;
         FUNC_DEC: g = 2'd2;
         FUNC_OCT: g = 2'd2;
         FUNC_BIN: g = 2'd3;
         default:  g = 2'd3;
      endcase
      return g;
   endfunction

   function automatic logic [CHAR_W-1:0] sep_char(input logic [FUNC_W-1:0] func);
      return (func == FUNC_DEC) ? CHR_COMMA : CHR_SPACE;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] base;
      base = (d < 4'd10) ? CHR_ZERO : CHR_ALPHA_BASE;
      return base + CHAR_W'(d);
   endfunction

endpackage

@@ design/grdf_cell.sv @@
// One digit cell of the serial converter: shifts a bit in from below and
// passes its top bit up; decimal mode applies the add-3 correction. Uses grdf_pkg.
module grdf_cell (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          shift,
   input  logic [grdf_pkg::FUNC_W-1:0]   func,
   input  logic                          carry_in,
   output logic [grdf_pkg::DIGIT_W-1:0]  digit,
   output logic                          carry_out,
   output logic                          nz_next
);

   logic [grdf_pkg::DIGIT_W-1:0] digit_ff;
   logic [grdf_pkg::DIGIT_W-1:0] digit_in;
   logic [grdf_pkg::DIGIT_W-1:0] adj;
   logic [grdf_pkg::DIGIT_W-1:0] shifted;

   always_comb begin
      adj = digit_ff;
      if (func == grdf_pkg::FUNC_DEC && digit_ff >= 4'd5) begin
         adj = digit_ff + 4'd3;
      end
      case (func)
         grdf_pkg::FUNC_HEX, grdf_pkg::FUNC_DEC: begin
            shifted   = {adj[2:0], carry_in};
            carry_out = adj[3];
         end
         grdf_pkg::FUNC_OCT: begin
            shifted   = {1'b0, digit_ff[1:0], carry_in};
            carry_out = digit_ff[2];
         end
         default: begin
            shifted   = {3'b000, carry_in};
            carry_out = digit_ff[0];
         end
      endcase
      if (clear) begin
         digit_in = '0;
      end else if (shift) begin
         digit_in = shifted;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit   = digit_ff;
   assign nz_next = (shifted != '0);

endmodule

@@ design/grdf_convert.sv @@
// Bit-serial converter: shifts the value in MSB first through a row of digit
// cells and tracks the digit count and its phase within a group. Uses grdf_pkg, grdf_cell.
`include "grouped_radix_digit_formatter_defines.svh"
module grdf_convert (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [grdf_pkg::IN_WIDTH-1:0]   value,
   input  logic [grdf_pkg::FUNC_W-1:0]     func,
   output logic                            busy,
   output grdf_pkg::digit_row_type         digits,
   output grdf_pkg::conv_status_type       status
);

   logic [grdf_pkg::VALUE_WIDTH-1:0] val_ff, val_in;
   logic [grdf_pkg::CNT_W-1:0]       bits_ff, bits_in;
   logic [grdf_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [1:0]                       cmod_ff, cmod_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic                             last_bit;
   logic                             grow;
   logic [grdf_pkg::VALUE_WIDTH:0]   carry;
   logic [grdf_pkg::VALUE_WIDTH-1:0] nz;

   assign carry[0] = val_ff[grdf_pkg::VALUE_WIDTH-1];

   for (genvar i = 0; i < grdf_pkg::VALUE_WIDTH; i++) begin : g_cell
      grdf_cell u_cell (
         .clock     (clock),
         .clear     (load),
         .shift     (busy_ff),
         .func      (func),
         .carry_in  (carry[i]),
         .digit     (digits[i]),
         .carry_out (carry[i+1]),
         .nz_next   (nz[i])
      );
   end

   assign last_bit = (bits_ff == grdf_pkg::CNT_W'(grdf_pkg::VALUE_WIDTH - 1));
   // The value at most doubles per shift, so only the cell just above the top can wake up.
   assign grow = (count_ff < grdf_pkg::CNT_W'(grdf_pkg::VALUE_WIDTH)) &&
                 nz[count_ff[grdf_pkg::IDX_W-1:0]];

   always_comb begin
      val_in   = val_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      cmod_in  = cmod_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (load) begin
         val_in   = grdf_pkg::VALUE_WIDTH'(value);
         bits_in  = '0;
         count_in = '0;
         cmod_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[grdf_pkg::VALUE_WIDTH-2:0], 1'b0};
         bits_in = bits_ff + 1'b1;
         if (grow) begin
            count_in = count_ff + 1'b1;
            cmod_in  = (cmod_ff == grdf_pkg::group_max(func)) ? 2'd0 : cmod_ff + 2'd1;
         end
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // A zero value still prints one digit.
            if (count_in == '0) begin
               count_in = grdf_pkg::CNT_W'(1);
               cmod_in  = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      bits_ff <= bits_in;
      cmod_ff <= cmod_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   assign busy          = busy_ff;
   assign status.done   = done_ff;
   assign status.count  = count_ff;
   assign status.cmod   = cmod_ff;

   `GRDF_ASSERT(a_busy_done_excl, !(busy_ff && done_ff))
   `GRDF_ASSERT(a_count_bound, count_ff <= grdf_pkg::CNT_W'(grdf_pkg::VALUE_WIDTH))
   `GRDF_ASSERT(a_done_nonzero, !done_ff || count_ff != '0)

endmodule

@@ design/grdf_emit.sv @@
// Character sequencer: walks the digits from the top down, inserts group
// separators and holds each character in the output register. Uses grdf_pkg.
`include "grouped_radix_digit_formatter_defines.svh"
module grdf_emit (
   input  logic                               clock,
   input  logic                               reset,
   input  grdf_pkg::conv_status_type          status,
   input  grdf_pkg::digit_row_type            digits,
   input  logic [grdf_pkg::FUNC_W-1:0]        func,
   input  logic                               rsp_stall,
   output logic                               busy,
   output logic                               rsp_valid,
   output logic [grdf_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                               rsp_last_char
);

   logic                         act_ff, act_in;
   logic                         sep_ff, sep_in;
   logic [grdf_pkg::IDX_W-1:0]   pos_ff, pos_in;
   logic [1:0]                   pmod_ff, pmod_in;
   logic                         valid_ff, valid_in;
   logic [grdf_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic                         last_ff, last_in;
   logic                         out_free;
   logic [grdf_pkg::CNT_W-1:0]   cnt_dec;
   logic [1:0]                   gmax;
   logic [1:0]                   pmod_dec;

   assign out_free = !valid_ff || !rsp_stall;
   assign cnt_dec  = status.count - grdf_pkg::CNT_W'(1);
   assign gmax     = grdf_pkg::group_max(func);
   assign pmod_dec = (pmod_ff == 2'd0) ? gmax : pmod_ff - 2'd1;

   always_comb begin
      act_in   = act_ff;
      sep_in   = sep_ff;
      pos_in   = pos_ff;
      pmod_in  = pmod_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (status.done) begin
         act_in  = 1'b1;
         sep_in  = 1'b0;
         pos_in  = cnt_dec[grdf_pkg::IDX_W-1:0];
         pmod_in = (status.cmod == 2'd0) ? gmax : status.cmod - 2'd1;
      end
      if (out_free) begin
         valid_in = act_ff;
         if (act_ff) begin
            if (sep_ff) begin
               char_in = grdf_pkg::sep_char(func);
               last_in = 1'b0;
               sep_in  = 1'b0;
               pos_in  = pos_ff - 1'b1;
               pmod_in = pmod_dec;
            end else begin
               char_in = grdf_pkg::glyph(digits[pos_ff]);
               last_in = (pos_ff == '0);
               if (pos_ff == '0) begin
                  act_in = 1'b0;
               end else if (pmod_ff == 2'd0) begin
                  // Group boundary: the separator goes out next, then advance.
                  sep_in = 1'b1;
               end else begin
                  pos_in  = pos_ff - 1'b1;
                  pmod_in = pmod_dec;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      pmod_ff <= pmod_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         act_ff   <= 1'b0;
         sep_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         sep_ff   <= sep_in;
         valid_ff <= valid_in;
      end
   end

   assign busy          = act_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   `GRDF_ASSERT(a_start_when_idle, !status.done || !act_ff)
   `GRDF_ASSERT(a_sep_not_bottom, !sep_ff || pos_ff != '0)
   `GRDF_ASSERT_NEXT(a_last_ends_text, valid_ff && last_ff && !rsp_stall && !act_ff, !valid_ff)

endmodule

@@ design/grouped_radix_digit_formatter.sv @@
// One item at a time: a new item is taken once the one-bit-per-cycle conversion pass
// is done and its characters (1 to 39) have gone to the output register, one character
// per cycle while rsp_stall is low.
// Reset: synchronous, clears the sequencing and output valid; the digit cells
// hold no defined value until the first item loads them.
module grouped_radix_digit_formatter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [grdf_pkg::IN_WIDTH-1:0]    req_value,
   input  logic [grdf_pkg::FUNC_W-1:0]      req_func,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [grdf_pkg::CHAR_W-1:0]      rsp_out_char,
   output logic                             rsp_last_char
);

   logic [grdf_pkg::FUNC_W-1:0] func_ff, func_in;
   logic                        accept;
   logic                        conv_busy;
   logic                        emit_busy;
   grdf_pkg::digit_row_type     digits;
   grdf_pkg::conv_status_type   status;

   // Hold off new beats from load until the last character is in the output register.
   assign req_stall = conv_busy || status.done || emit_busy;
   assign accept    = req_valid && !req_stall;
   assign func_in   = accept ? req_func : func_ff;

   always_ff @(posedge clock) begin
      func_ff <= func_in;
   end

   grdf_convert u_convert (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .value  (req_value),
      .func   (func_ff),
      .busy   (conv_busy),
      .digits (digits),
      .status (status)
   );

   grdf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .status        (status),
      .digits        (digits),
      .func          (func_ff),
      .rsp_stall     (rsp_stall),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ sim/tb_grouped_radix_digit_formatter.sv @@
// Self-checking testbench for grouped_radix_digit_formatter: drives numbers and radix
// selectors, predicts the grouped ASCII text and checks every character beat.
// Depends on grdf_pkg and the formatter RTL only.
module tb_grouped_radix_digit_formatter;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = grdf_pkg::VALUE_WIDTH + 3 + 40 + 20;
   localparam int MAX_REPORTS    = 10;
   localparam int JOBS_PER_PHASE = 98;
   localparam logic [grdf_pkg::CHAR_W-1:0] CHR_UPPER_A = 7'h41;

   typedef struct {
      logic [grdf_pkg::IN_WIDTH-1:0] value;
      logic [grdf_pkg::FUNC_W-1:0]   func;
      bit                            drain_first;
   } format_job_type;

   typedef struct {
      logic [grdf_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } char_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [grdf_pkg::IN_WIDTH-1:0] req_value = '0;
   logic [grdf_pkg::FUNC_W-1:0]   req_func = grdf_pkg::FUNC_HEX;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [grdf_pkg::CHAR_W-1:0]   rsp_out_char;
   logic                          rsp_last_char;

   format_job_type job_backlog[$];
   char_beat_type  pending_chars[$];
   int             jobs_queued = 0;
   int             jobs_taken = 0;
   int             chars_outstanding = 0;
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;

   grouped_radix_digit_formatter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_func      (req_func),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Append the grouped text of one number to the character queue.
   function automatic void queue_formatted_text(input logic [grdf_pkg::IN_WIDTH-1:0] value,
                                                input logic [grdf_pkg::FUNC_W-1:0] func);
      longint unsigned             rest;
      longint unsigned             radix;
      int                          group;
      int                          n_digits;
      logic [grdf_pkg::CHAR_W-1:0] sep;
      logic [3:0]                  digits [grdf_pkg::VALUE_WIDTH];
      char_beat_type               beat;
      case (func)
         grdf_pkg::FUNC_HEX: begin
            radix = 16; group = 4; sep = grdf_pkg::CHR_SPACE;
         end
         grdf_pkg::FUNC_DEC: begin
            radix = 10; group = 3; sep = grdf_pkg::CHR_COMMA;
         end
         grdf_pkg::FUNC_OCT: begin
            radix = 8; group = 3; sep = grdf_pkg::CHR_SPACE;
         end
         default: begin
            radix = 2; group = 4; sep = grdf_pkg::CHR_SPACE;
         end
      endcase
      rest = 64'(value[grdf_pkg::VALUE_WIDTH-1:0]);
      n_digits = 0;
      do begin
         if (n_digits < grdf_pkg::VALUE_WIDTH) begin
            digits[n_digits] = 4'(rest % radix);
            n_digits++;
         end
         rest = rest / radix;
      end while (rest != 0);
      for (int pos = n_digits - 1; pos >= 0; pos--) begin
         if (digits[pos] < 4'd10)
            beat.ch = grdf_pkg::CHR_ZERO + grdf_pkg::CHAR_W'(digits[pos]);
         else
            beat.ch = CHR_UPPER_A + grdf_pkg::CHAR_W'(digits[pos] - 4'd10);
         beat.last = (pos == 0);
         pending_chars.push_back(beat);
         if (pos != 0 && pos % group == 0) begin
            beat.ch = sep;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
         end
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH: %s", msg);
   endtask

   // Sender: hold a stalled beat, otherwise launch the next job or idle.
   always @(posedge clock) begin : drive_jobs
      format_job_type job;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (job_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct &&
             (!job_backlog[0].drain_first || (!req_valid && chars_outstanding == 0))) begin
            job = job_backlog.pop_front();
            req_valid <= 1'b1;
            req_value <= job.value;
            req_func  <= job.func;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
   end

   // Check the result beat first, then predict from the input beat at this edge.
   always @(posedge clock) begin : watch_beats
      char_beat_type want;
      if (reset) begin
         chars_outstanding <= 0;
         jobs_taken <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               flag_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                       rsp_out_char, rsp_last_char));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_out_char !== want.ch || rsp_last_char !== want.last)
                  flag_mismatch($sformatf("char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                                          want.ch, want.last, rsp_out_char, rsp_last_char));
            end
         end
         if (req_valid && !req_stall) begin
            queue_formatted_text(req_value, req_func);
            jobs_taken <= jobs_taken + 1;
         end
         chars_outstanding <= pending_chars.size();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("grouped_radix_digit_formatter regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_job(input logic [grdf_pkg::IN_WIDTH-1:0] value,
                          input logic [grdf_pkg::FUNC_W-1:0] func,
                          input bit drain_first);
      format_job_type job;
      job.value = value;
      job.func = func;
      job.drain_first = drain_first;
      job_backlog.push_back(job);
      jobs_queued++;
   endtask

   task automatic await_drain();
      while (jobs_taken != jobs_queued || chars_outstanding != 0)
         @(posedge clock);
   endtask

   // Random bit lengths from zero to full width, so that group boundaries come up often.
   task automatic add_random_jobs(input int count);
      logic [grdf_pkg::IN_WIDTH-1:0] value;
      int                            n_bits;
      for (int i = 0; i < count; i++) begin
         value = $urandom;
         n_bits = $urandom_range(grdf_pkg::IN_WIDTH, 0);
         if (n_bits < grdf_pkg::IN_WIDTH)
            value = value & ((grdf_pkg::IN_WIDTH'(1) << n_bits) - 1);
         add_job(value, grdf_pkg::FUNC_W'($urandom_range(3, 0)), (i % 40) == 20);
      end
   endtask

   initial begin : stimulus
      int send_pct [4];
      int recv_pct [4];
      send_pct = '{0, 60, 0, 6};
      recv_pct = '{0, 0, 60, 6};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      add_job(32'd0, grdf_pkg::FUNC_HEX, 1'b0);
      add_job(32'd0, grdf_pkg::FUNC_DEC, 1'b0);
      add_job(32'd0, grdf_pkg::FUNC_OCT, 1'b0);
      add_job(32'd0, grdf_pkg::FUNC_BIN, 1'b0);
      add_job(32'hFFFF_FFFF, grdf_pkg::FUNC_HEX, 1'b0);
      add_job(32'hFFFF_FFFF, grdf_pkg::FUNC_DEC, 1'b0);
      add_job(32'hFFFF_FFFF, grdf_pkg::FUNC_OCT, 1'b0);
      add_job(32'hFFFF_FFFF, grdf_pkg::FUNC_BIN, 1'b0);
      add_job(32'h8000_0000, grdf_pkg::FUNC_HEX, 1'b0);
      add_job(32'hFEDC_BA98, grdf_pkg::FUNC_HEX, 1'b0);
      // Group boundaries: one digit short of and one past a separator.
      add_job(32'h0000_1234, grdf_pkg::FUNC_HEX, 1'b0);
      add_job(32'h0001_2345, grdf_pkg::FUNC_HEX, 1'b0);
      add_job(32'd999, grdf_pkg::FUNC_DEC, 1'b0);
      add_job(32'd1000, grdf_pkg::FUNC_DEC, 1'b1);
      add_job(32'd1000000, grdf_pkg::FUNC_DEC, 1'b0);
      add_job(32'd511, grdf_pkg::FUNC_OCT, 1'b0);
      add_job(32'd512, grdf_pkg::FUNC_OCT, 1'b0);
      add_job(32'd15, grdf_pkg::FUNC_BIN, 1'b0);
      add_job(32'd16, grdf_pkg::FUNC_BIN, 1'b0);
      add_job(32'd1, grdf_pkg::FUNC_BIN, 1'b0);
      await_drain();

      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         send_idle_pct = send_pct[p];
         recv_stall_pct = recv_pct[p];
         add_random_jobs(JOBS_PER_PHASE);
         await_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && chars_outstanding == 0)
         $display("grouped_radix_digit_formatter regression: pass");
      else
         $display("grouped_radix_digit_formatter regression: fail");
      $finish;
   end

endmodule
